// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion shorthands, sampled on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FTA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define FTA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- hw/rtl/fta_pkg.sv -----
// ----------------------------------------------------------------------------
// fta_pkg
// shared types and constants of the fire texture automaton
// ----------------------------------------------------------------------------
package fta_pkg;

    localparam int MUL_W = 32;

    // request command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // result kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_COLOR = 1'b1;

    // floor(2^32 * 25 / 636), heat decay reciprocal
    localparam logic [MUL_W-1:0] DIV_MAGIC = MUL_W'((64'd25 << 32) / 64'd636);
    localparam logic [MUL_W-1:0] DIV_SCALE = MUL_W'(636);
    // floor(2^32 / 5)
    localparam logic [MUL_W-1:0] FIFTH_MAGIC = MUL_W'((64'd1 << 32) / 64'd5);
    // 65536 = 5 * 13107 + 1
    localparam logic [MUL_W-1:0] FIFTH_SCALE = MUL_W'(13107);
    localparam logic [MUL_W-1:0] RED_SPAN    = MUL_W'(155);
    localparam logic [7:0]       RED_BASE    = 8'd100;
    // 0.1 and 0.2 in Q32
    localparam logic [MUL_W-1:0] SEED_TENTH  = MUL_W'(429496730);
    localparam logic [35:0]      SEED_OFFSET = 36'd858993459;

    localparam logic [16:0] SCALE_ONE = 17'd65536;

    typedef struct packed {
        logic        load;
        logic [31:0] seed;
        logic        step;
    } rng_ctrl_t;

endpackage

// ----- hw/rtl/fta_req_if.sv -----
// ----------------------------------------------------------------------------
// fta_req_if
// request channel: tick or cell read
// ----------------------------------------------------------------------------
interface fta_req_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic       layer;
    logic [3:0] column;
    logic [3:0] row;

    modport source (output valid, output command, output layer, output column,
                    output row, input ready);
    modport sink (input valid, input command, input layer, input column,
                  input row, output ready);
endinterface

// ----- hw/rtl/fta_rsp_if.sv -----
// ----------------------------------------------------------------------------
// fta_rsp_if
// response channel: tick done or pixel color
// ----------------------------------------------------------------------------
interface fta_rsp_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [31:0] pixel_color;

    modport source (output valid, output result_kind, output pixel_color, input ready);
    modport sink (input valid, input result_kind, input pixel_color, output ready);
endinterface

// ----- hw/rtl/fta_cfg_if.sv -----
// ----------------------------------------------------------------------------
// fta_cfg_if
// configuration write channel: random seed
// ----------------------------------------------------------------------------
interface fta_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] random_seed;

    modport source (output valid, output random_seed, input ready);
    modport sink (input valid, input random_seed, output ready);
endinterface

// ----- hw/rtl/fta_mul.sv -----
// ----------------------------------------------------------------------------
// fta_mul
// shared unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module fta_mul
    import fta_pkg::*;
(
    input  logic                 clk,
    input  logic [MUL_W-1:0]     a,
    input  logic [MUL_W-1:0]     b,
    output logic [2*MUL_W-1:0]   product
);

    logic [2*MUL_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= (2*MUL_W)'(a) * (2*MUL_W)'(b);
    end

    assign product = product_reg;

endmodule

// ----- hw/rtl/fta_rng.sv -----
// ----------------------------------------------------------------------------
// fta_rng
// xorshift32 generator, seed load and step, top 16 bits per draw
// ----------------------------------------------------------------------------
module fta_rng
    import fta_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rng_ctrl_t   ctrl,
    output logic [15:0] draw
);

    logic [31:0] state_reg;
    logic [31:0] state_next;
    logic [31:0] s1;
    logic [31:0] s2;
    logic [31:0] stepped;

    assign s1      = state_reg ^ (state_reg << 13);
    assign s2      = s1 ^ (s1 >> 17);
    assign stepped = s2 ^ (s2 << 5);
    assign draw    = stepped[31:16];

    always_comb
    begin
        state_next = state_reg;
        if (ctrl.load)
        begin
            state_next = (ctrl.seed == 32'd0) ? 32'd1 : ctrl.seed;
        end
        else if (ctrl.step)
        begin
            state_next = stepped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= 32'd1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hw/rtl/fire_texture_automaton.sv -----
// ----------------------------------------------------------------------------
// fire_texture_automaton
// two fire heat grids with tick update, reseeding and color lookup
// ----------------------------------------------------------------------------
// request carries a word: command tick or read (layer, column, row).
// response returns one word per request: kind 0 for a finished tick,
// kind 1 with the packed alpha/blue/green/red color of the cell.
// seed_cfg writes the xorshift32 seed and restarts the generator.
// a read runs from accept to response valid through one memory read
// and seven passes through the shared multiplier.
// a tick's length is set by the single memory read port (three reads and a
// sum per row) and the multiplier (two passes per cell, three per reseeded
// bottom-row cell).
// request.ready is high only while no item is in work.
// after reset the current heat bank is swept to zero, one entry a cycle,
// 2^(layer, row and column address bits) entries (1024 by default), before
// the first request is taken; seed writes are taken at any time.
// a stalled response holds in its output register; the next request is
// still taken and its result waits until that register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fire_texture_automaton
    import fta_pkg::*;
#(
    parameter int GRID_WIDTH  = 16,
    parameter int GRID_HEIGHT = 20,
    parameter int LAYER_COUNT = 2,
    parameter int HEAT_BITS   = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    fta_req_if.sink  request,
    fta_rsp_if.source response,
    fta_cfg_if.sink  seed_cfg
);

    localparam int XB = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
    localparam int YB = $clog2(GRID_HEIGHT);
    localparam int LB = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
    localparam int CB = LB + YB + XB;
    localparam int AW = CB + 1;
    localparam int DEPTH = 2 ** AW;
    localparam int FB = HEAT_BITS - 3;
    localparam int RB = HEAT_BITS + 2;
    localparam int SB = HEAT_BITS + 5;
    localparam int TB = SB + 5;
    localparam int AB = HEAT_BITS + 4;

    localparam logic [XB-1:0] LAST_X = XB'(GRID_WIDTH - 1);
    localparam logic [YB-1:0] LAST_Y = YB'(GRID_HEIGHT - 1);
    localparam logic [LB-1:0] LAST_L = LB'(LAYER_COUNT - 1);
    localparam logic [35:0]   HEAT_MAX = 36'((64'd1 << HEAT_BITS) - 64'd1);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE,
        ST_COL_RD, ST_COL_A, ST_COL_Q, ST_COL_S, ST_COL_G, ST_COL_R,
        ST_COL_P4, ST_COL_P8, ST_COL_B,
        ST_ROW_L, ST_ROW_C, ST_ROW_R, ST_ROW_SUM, ST_DIV_Q, ST_DIV_FIX,
        ST_SEED_1, ST_SEED_2, ST_SEED_3, ST_SEED_4, ST_SEED_5,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    logic [HEAT_BITS-1:0] heat_mem [DEPTH];
    logic [HEAT_BITS-1:0] rd_data_reg;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [HEAT_BITS-1:0] wr_data;

    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [2*MUL_W-1:0] prod;

    rng_ctrl_t   rng_ctrl;
    logic [15:0] draw;

    logic                 buffer_select_reg, buffer_select_next;
    logic [XB-1:0]        x_reg, x_next;
    logic [YB-1:0]        y_reg, y_next;
    logic [LB-1:0]        layer_reg, layer_next;
    logic [CB-1:0]        clr_reg, clr_next;
    logic [AW-1:0]        col_addr_reg, col_addr_next;
    logic                 in_range_reg, in_range_next;
    logic [RB-1:0]        rsum_reg, rsum_next;
    logic [RB-1:0]        rprev_reg, rprev_next;
    logic [HEAT_BITS-1:0] cen_reg, cen_next;
    logic [SB-1:0]        s_reg, s_next;
    logic [SB-1:0]        q0_reg, q0_next;
    logic [AB-1:0]        a_reg, a_next;
    logic [AB-1:0]        qa_reg, qa_next;
    logic [16:0]          sval_reg, sval_next;
    logic [16:0]          p2_reg, p2_next;
    logic [7:0]           green_reg, green_next;
    logic [7:0]           red_reg, red_next;
    logic [15:0]          r1_reg, r1_next;
    logic [35:0]          acc_reg, acc_next;
    logic                 res_kind_reg, res_kind_next;
    logic [31:0]          res_color_reg, res_color_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_kind_reg, out_kind_next;
    logic [31:0]          out_color_reg, out_color_next;

    // request field decode
    logic [31:0] req_layer;
    logic [31:0] req_col;
    logic [31:0] req_row;

    // stencil datapath
    logic [RB-1:0]        row_total;
    logic [SB-1:0]        s_sum;
    logic [TB-1:0]        s25;
    logic [TB-1:0]        rem;
    logic [SB-1:0]        q_fix;

    // reseed datapath
    logic [35:0] seed_t;
    logic [35:0] seed_h;
    logic [35:0] seed_sat;

    // color datapath
    logic [HEAT_BITS-1:0] v_c;
    logic [AB-1:0]        a_c;
    logic [AB-1:0]        q0a;
    logic [AB-1:0]        chk;
    logic [63:0]          sr;
    logic [16:0]          s_c;
    logic [40:0]          g41;
    logic [24:0]          b25;
    logic [7:0]           alpha;

    fta_mul u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (prod)
    );

    fta_rng u_rng (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (rng_ctrl),
        .draw  (draw)
    );

    assign req_layer = 32'(request.layer);
    assign req_col   = 32'(request.column);
    assign req_row   = 32'(request.row);

    assign row_total = rsum_reg + ((x_reg != LAST_X) ? RB'(rd_data_reg) : RB'(0));
    assign s_sum     = SB'(rprev_reg) + SB'(row_total)
                     + (SB'(cen_reg) << 4) + (SB'(cen_reg) << 1);
    assign s25       = (TB'(s_reg) << 4) + (TB'(s_reg) << 3) + TB'(s_reg);
    assign rem       = s25 - TB'(prod);
    assign q_fix     = (rem >= TB'(DIV_SCALE)) ? (q0_reg + SB'(1)) : q0_reg;

    assign seed_t   = acc_reg + 36'(prod[63:16]) + SEED_OFFSET;
    assign seed_h   = seed_t >> (32 - FB);
    assign seed_sat = (seed_h > HEAT_MAX) ? HEAT_MAX : seed_h;

    assign v_c   = in_range_reg ? rd_data_reg : '0;
    assign a_c   = (AB'(v_c) << 3) + AB'(v_c);
    assign q0a   = AB'(prod[63:32]);
    assign chk   = a_reg - ((q0a << 2) + q0a);
    assign sr    = (prod + 64'(qa_reg)) >> FB;
    assign s_c   = (sr > 64'(SCALE_ONE)) ? SCALE_ONE : 17'(sr);
    assign g41   = {prod[32:0], 8'd0} - 41'(prod[32:0]);
    assign b25   = {prod[32:16], 8'd0} - 25'(prod[32:16]);
    assign alpha = (sval_reg[16] | sval_reg[15]) ? 8'hff : 8'h00;

    assign request.ready  = (state_reg == ST_IDLE);
    assign seed_cfg.ready = 1'b1;

    assign response.valid       = out_valid_reg;
    assign response.result_kind = out_kind_reg;
    assign response.pixel_color = out_color_reg;

    always_comb
    begin
        state_next         = state_reg;
        buffer_select_next = buffer_select_reg;
        x_next             = x_reg;
        y_next             = y_reg;
        layer_next         = layer_reg;
        clr_next           = clr_reg;
        col_addr_next      = col_addr_reg;
        in_range_next      = in_range_reg;
        rsum_next          = rsum_reg;
        rprev_next         = rprev_reg;
        cen_next           = cen_reg;
        s_next             = s_reg;
        q0_next            = q0_reg;
        a_next             = a_reg;
        qa_next            = qa_reg;
        sval_next          = sval_reg;
        p2_next            = p2_reg;
        green_next         = green_reg;
        red_next           = red_reg;
        r1_next            = r1_reg;
        acc_next           = acc_reg;
        res_kind_next      = res_kind_reg;
        res_color_next     = res_color_reg;
        out_valid_next     = out_valid_reg;
        out_kind_next      = out_kind_reg;
        out_color_next     = out_color_reg;

        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = '0;
        mul_a    = '0;
        mul_b    = '0;

        rng_ctrl.load = seed_cfg.valid;
        rng_ctrl.seed = seed_cfg.random_seed;
        rng_ctrl.step = 1'b0;

        if (out_valid_reg && response.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = {1'b0, clr_reg};
                clr_next = clr_reg + CB'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (request.valid)
                begin
                    if (request.command == CMD_READ)
                    begin
                        col_addr_next = {buffer_select_reg, req_layer[LB-1:0],
                                         req_row[YB-1:0], req_col[XB-1:0]};
                        in_range_next = (req_layer < 32'(LAYER_COUNT))
                                     && (req_row < 32'(GRID_HEIGHT))
                                     && (req_col < 32'(GRID_WIDTH));
                        state_next    = ST_COL_RD;
                    end
                    else
                    begin
                        x_next     = '0;
                        y_next     = '0;
                        layer_next = '0;
                        state_next = ST_ROW_L;
                    end
                end
            end

            // color lookup
            ST_COL_RD:
            begin
                rd_addr    = col_addr_reg;
                state_next = ST_COL_A;
            end

            ST_COL_A:
            begin
                a_next     = a_c;
                mul_a      = MUL_W'(a_c);
                mul_b      = FIFTH_MAGIC;
                state_next = ST_COL_Q;
            end

            ST_COL_Q:
            begin
                qa_next    = (chk >= AB'(5)) ? (q0a + AB'(1)) : q0a;
                mul_a      = MUL_W'(a_reg);
                mul_b      = FIFTH_SCALE;
                state_next = ST_COL_S;
            end

            ST_COL_S:
            begin
                sval_next  = s_c;
                mul_a      = MUL_W'(s_c);
                mul_b      = MUL_W'(s_c);
                state_next = ST_COL_G;
            end

            ST_COL_G:
            begin
                green_next = g41[39:32];
                p2_next    = prod[32:16];
                mul_a      = MUL_W'(sval_reg);
                mul_b      = RED_SPAN;
                state_next = ST_COL_R;
            end

            ST_COL_R:
            begin
                red_next   = RED_BASE + prod[23:16];
                mul_a      = MUL_W'(p2_reg);
                mul_b      = MUL_W'(p2_reg);
                state_next = ST_COL_P4;
            end

            ST_COL_P4:
            begin
                mul_a      = MUL_W'(prod[32:16]);
                mul_b      = MUL_W'(prod[32:16]);
                state_next = ST_COL_P8;
            end

            ST_COL_P8:
            begin
                mul_a      = MUL_W'(prod[32:16]);
                mul_b      = MUL_W'(p2_reg);
                state_next = ST_COL_B;
            end

            ST_COL_B:
            begin
                res_kind_next  = KIND_COLOR;
                res_color_next = {alpha, b25[23:16], green_reg, red_reg};
                state_next     = ST_FINISH;
            end

            // stencil, one row of three cells per pass
            ST_ROW_L:
            begin
                rd_addr    = {buffer_select_reg, layer_reg, y_reg, x_reg - XB'(1)};
                state_next = ST_ROW_C;
            end

            ST_ROW_C:
            begin
                rd_addr    = {buffer_select_reg, layer_reg, y_reg, x_reg};
                rsum_next  = (x_reg != '0) ? RB'(rd_data_reg) : RB'(0);
                state_next = ST_ROW_R;
            end

            ST_ROW_R:
            begin
                rd_addr    = {buffer_select_reg, layer_reg, y_reg, x_reg + XB'(1)};
                rsum_next  = rsum_reg + RB'(rd_data_reg);
                cen_next   = rd_data_reg;
                state_next = ST_ROW_SUM;
            end

            ST_ROW_SUM:
            begin
                rprev_next = row_total;
                if (y_reg == '0)
                begin
                    y_next     = y_reg + YB'(1);
                    state_next = ST_ROW_L;
                end
                else
                begin
                    s_next     = s_sum;
                    mul_a      = MUL_W'(s_sum);
                    mul_b      = DIV_MAGIC;
                    state_next = ST_DIV_Q;
                end
            end

            ST_DIV_Q:
            begin
                q0_next    = SB'(prod[63:32]);
                mul_a      = MUL_W'(SB'(prod[63:32]));
                mul_b      = DIV_SCALE;
                state_next = ST_DIV_FIX;
            end

            ST_DIV_FIX:
            begin
                wr_en   = 1'b1;
                wr_addr = {~buffer_select_reg, layer_reg, y_reg - YB'(1), x_reg};
                wr_data = HEAT_BITS'(q_fix);
                state_next = ST_ROW_L;
                if (y_reg == LAST_Y)
                begin
                    y_next = '0;
                    if (x_reg == LAST_X)
                    begin
                        x_next = '0;
                        if (layer_reg == LAST_L)
                        begin
                            layer_next = '0;
                            state_next = ST_SEED_1;
                        end
                        else
                        begin
                            layer_next = layer_reg + LB'(1);
                        end
                    end
                    else
                    begin
                        x_next = x_reg + XB'(1);
                    end
                end
                else
                begin
                    y_next = y_reg + YB'(1);
                end
            end

            // bottom row reseed
            ST_SEED_1:
            begin
                rng_ctrl.step = 1'b1;
                r1_next       = draw;
                state_next    = ST_SEED_2;
            end

            ST_SEED_2:
            begin
                rng_ctrl.step = 1'b1;
                mul_a         = MUL_W'(r1_reg);
                mul_b         = MUL_W'(draw);
                state_next    = ST_SEED_3;
            end

            ST_SEED_3:
            begin
                rng_ctrl.step = 1'b1;
                mul_a         = prod[MUL_W-1:0];
                mul_b         = MUL_W'(draw);
                state_next    = ST_SEED_4;
            end

            ST_SEED_4:
            begin
                rng_ctrl.step = 1'b1;
                acc_next      = 36'(prod >> 14);
                mul_a         = MUL_W'(draw);
                mul_b         = SEED_TENTH;
                state_next    = ST_SEED_5;
            end

            ST_SEED_5:
            begin
                wr_en      = 1'b1;
                wr_addr    = {~buffer_select_reg, layer_reg, LAST_Y, x_reg};
                wr_data    = HEAT_BITS'(seed_sat);
                state_next = ST_SEED_1;
                if (x_reg == LAST_X)
                begin
                    x_next = '0;
                    if (layer_reg == LAST_L)
                    begin
                        layer_next         = '0;
                        buffer_select_next = ~buffer_select_reg;
                        res_kind_next      = KIND_TICK;
                        res_color_next     = '0;
                        state_next         = ST_FINISH;
                    end
                    else
                    begin
                        layer_next = layer_reg + LB'(1);
                    end
                end
                else
                begin
                    x_next = x_reg + XB'(1);
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || response.ready)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = res_kind_reg;
                    out_color_next = res_color_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            buffer_select_reg <= 1'b0;
            x_reg             <= '0;
            y_reg             <= '0;
            layer_reg         <= '0;
            clr_reg           <= '0;
            col_addr_reg      <= '0;
            in_range_reg      <= 1'b0;
            rsum_reg          <= '0;
            rprev_reg         <= '0;
            cen_reg           <= '0;
            s_reg             <= '0;
            q0_reg            <= '0;
            a_reg             <= '0;
            qa_reg            <= '0;
            sval_reg          <= '0;
            p2_reg            <= '0;
            green_reg         <= '0;
            red_reg           <= '0;
            r1_reg            <= '0;
            acc_reg           <= '0;
            res_kind_reg      <= KIND_TICK;
            res_color_reg     <= '0;
            out_valid_reg     <= 1'b0;
            out_kind_reg      <= KIND_TICK;
            out_color_reg     <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            buffer_select_reg <= buffer_select_next;
            x_reg             <= x_next;
            y_reg             <= y_next;
            layer_reg         <= layer_next;
            clr_reg           <= clr_next;
            col_addr_reg      <= col_addr_next;
            in_range_reg      <= in_range_next;
            rsum_reg          <= rsum_next;
            rprev_reg         <= rprev_next;
            cen_reg           <= cen_next;
            s_reg             <= s_next;
            q0_reg            <= q0_next;
            a_reg             <= a_next;
            qa_reg            <= qa_next;
            sval_reg          <= sval_next;
            p2_reg            <= p2_next;
            green_reg         <= green_next;
            red_reg           <= red_next;
            r1_reg            <= r1_next;
            acc_reg           <= acc_next;
            res_kind_reg      <= res_kind_next;
            res_color_reg     <= res_color_next;
            out_valid_reg     <= out_valid_next;
            out_kind_reg      <= out_kind_next;
            out_color_reg     <= out_color_next;
        end
    end

    // heat store, both banks
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heat_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= heat_mem[rd_addr];
    end

    `FTA_ASSERT_IMP(a_no_accept_in_clear, state_reg == ST_CLEAR, !request.ready)
    `FTA_ASSERT_IMP(a_write_other_bank, wr_en && (state_reg != ST_CLEAR),
                    wr_addr[AW-1] != buffer_select_reg)
    `FTA_ASSERT_IMP(a_tick_word_zero, out_valid_reg && (out_kind_reg == KIND_TICK),
                    out_color_reg == 32'd0)
    `FTA_ASSERT_NXT(a_finish_to_idle,
                    (state_reg == ST_FINISH) && (!out_valid_reg || response.ready),
                    out_valid_reg && (state_reg == ST_IDLE))

endmodule
